[rtl/jos_pkg.sv]
package jos_pkg;

    localparam int KIND_W = 3;
    localparam int POS_W  = 7;
    localparam int STEP_W = 8;

    localparam logic [KIND_W-1:0] KIND_OUT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SURV     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NONPOS   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOO_MANY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic err_out;     // emit error result
        logic init_wr;     // set one alive flag
        logic walk_start;  // place cursor before start, clear elimination count
        logic hit_clr;
        logic adv;         // advance cursor, read its flag
        logic test;        // count a living member
        logic kill;        // clear flag at cursor, emit eliminated
        logic scan_clr;
        logic scan_rd;
        logic scan_step;   // emit survivor if alive, move scan pointer
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic init_last;
        logic elim_done;
        logic hit_done;
        logic alive;
        logic scan_last;
        logic slot_free;
    } t_status;

endpackage

[rtl/jos_dp.sv]
module jos_dp #(
    parameter int MAX_PEOPLE = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jos_pkg::t_cmd         i_cmd,
    output jos_pkg::t_status      o_status,
    input  logic [31:0]           i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,
    output logic [2:0]            o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int IW = $clog2(MAX_PEOPLE);
    localparam logic [6:0] MAXP = 7'(MAX_PEOPLE);

    logic [6:0]  r_n, r_s, r_k, r_ord;
    logic [7:0]  r_m, r_hit;
    logic [6:0]  r_elim;
    logic [IW-1:0] r_cur, r_wptr, r_scan;
    logic        r_rd;
    logic        r_alive [MAX_PEOPLE];

    logic        r_ovld, r_olast;
    logic [2:0]  r_okind;
    logic [6:0]  r_opos, r_oord;

    logic [6:0]  in_total;
    logic [IW-1:0] cur_next;
    logic        nonpos, too_many, bad_start;
    logic [2:0]  err_kind;
    logic        emit;
    logic [2:0]  e_kind;
    logic [6:0]  e_pos;
    logic        e_last;
    logic        wr_en, wr_val;
    logic [IW-1:0] wr_addr, rd_addr;

    assign in_total = i_s_tdata[6:0];
    assign cur_next = (7'(r_cur) + 7'd1 == r_n) ? '0 : IW'(7'(r_cur) + 7'd1);

    assign nonpos    = (r_n == 7'd0) || (r_s == 7'd0) || (r_m == 8'd0) || (r_k == 7'd0);
    assign too_many  = r_k > r_n;
    assign bad_start = r_s > r_n;

    always_comb begin
        if (nonpos) begin
            err_kind = jos_pkg::KIND_NONPOS;
        end else if (too_many) begin
            err_kind = jos_pkg::KIND_TOO_MANY;
        end else if (bad_start) begin
            err_kind = jos_pkg::KIND_START;
        end else begin
            err_kind = jos_pkg::KIND_OUT;
        end
    end

    assign emit = i_cmd.err_out || i_cmd.kill || (i_cmd.scan_step && r_rd);

    always_comb begin
        if (i_cmd.err_out) begin
            e_kind = err_kind;
            e_pos  = 7'd0;
            e_last = 1'b1;
        end else if (i_cmd.kill) begin
            e_kind = jos_pkg::KIND_OUT;
            e_pos  = 7'(r_cur) + 7'd1;
            e_last = (r_ord + 7'd1 == r_n);
        end else begin
            e_kind = jos_pkg::KIND_SURV;
            e_pos  = 7'(r_scan) + 7'd1;
            e_last = (r_ord + 7'd1 == r_n);
        end
    end

    assign o_status.err       = nonpos || too_many || bad_start;
    assign o_status.init_last = (7'(r_wptr) + 7'd1 == r_n);
    assign o_status.elim_done = (r_elim == r_n - r_k);
    assign o_status.hit_done  = r_rd && (r_hit + 8'd1 == r_m);
    assign o_status.alive     = r_rd;
    assign o_status.scan_last = (7'(r_scan) + 7'd1 == r_n);
    assign o_status.slot_free = !r_ovld || i_m_tready;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= (in_total > MAXP) ? MAXP : in_total;
            r_s    <= i_s_tdata[13:7];
            r_m    <= i_s_tdata[21:14];
            r_k    <= i_s_tdata[28:22];
            r_wptr <= '0;
        end
        if (i_cmd.init_wr) r_wptr <= IW'(7'(r_wptr) + 7'd1);
        if (i_cmd.walk_start) begin
            r_cur  <= (r_s >= 7'd2) ? IW'(r_s - 7'd2) : IW'(r_n - 7'd1);
            r_elim <= 7'd0;
        end
        if (i_cmd.hit_clr) r_hit <= 8'd0;
        if (i_cmd.adv) r_cur <= cur_next;
        if (i_cmd.test && r_rd) r_hit <= r_hit + 8'd1;
        if (i_cmd.kill) r_elim <= r_elim + 7'd1;
        if (i_cmd.scan_clr) r_scan <= '0;
        if (i_cmd.scan_step) r_scan <= IW'(7'(r_scan) + 7'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord <= 7'd0;
        end else if (i_cmd.load) begin
            r_ord <= 7'd0;
        end else if (emit) begin
            r_ord <= r_ord + 7'd1;
        end
    end

    // alive flag memory: one write port, one registered read port
    assign wr_en   = i_cmd.init_wr || i_cmd.kill;
    assign wr_val  = i_cmd.init_wr;
    assign wr_addr = i_cmd.init_wr ? r_wptr : r_cur;
    assign rd_addr = i_cmd.adv ? cur_next : r_scan;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_alive[wr_addr] <= wr_val;
        if (i_cmd.adv || i_cmd.scan_rd) r_rd <= r_alive[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (emit) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_okind <= e_kind;
            r_opos  <= e_pos;
            r_oord  <= r_ord + 7'd1;
            r_olast <= e_last;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {2'b00, r_oord, r_opos};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

    a_adv_below_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv |-> (r_hit < r_m))
        else $error("cursor advanced after step count reached");

    a_kill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.kill |-> (r_elim < r_n - r_k))
        else $error("elimination beyond survivor count");

    a_ord_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_oord != 7'd0))
        else $error("result with zero ordinal");

endmodule

[rtl/jos_ctrl.sv]
module jos_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  jos_pkg::t_status  i_status,
    output jos_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_ELIM  = 4'd4;
    localparam logic [3:0] S_ADV   = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_KILL  = 4'd7;
    localparam logic [3:0] S_SCRD  = 4'd8;
    localparam logic [3:0] S_SCTST = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.err ? S_ERR : S_INIT;
            end
            S_ERR: begin
                if (i_status.slot_free) begin
                    o_cmd.err_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_status.init_last) begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_ELIM;
                end
            end
            S_ELIM: begin
                if (i_status.elim_done) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCRD;
                end else begin
                    o_cmd.hit_clr = 1'b1;
                    n_state       = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state    = i_status.hit_done ? S_KILL : S_ADV;
            end
            S_KILL: begin
                if (i_status.slot_free) begin
                    o_cmd.kill = 1'b1;
                    n_state    = S_ELIM;
                end
            end
            S_SCRD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCTST;
            end
            S_SCTST: begin
                // a dead member moves on at once; a survivor waits for the output slot
                if (!i_status.alive || i_status.slot_free) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = i_status.scan_last ? S_IDLE : S_SCRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.err_out || o_cmd.kill || (o_cmd.scan_step && i_status.alive))
            |-> i_status.slot_free)
        else $error("result issued into a full output register");

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.err_out |=> (r_state == S_IDLE))
        else $error("error result did not end the item");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK) && !o_s_tready)
        else $error("item accepted without check");

endmodule

[rtl/josephus_elimination_order.sv]
// An error item gives its result from S_ERR after the check; output stalls delay it.
// Valid item: check and fill the ring, then for each elimination walk the ring one position
// at a time (S_ADV, S_TEST) and kill (S_KILL), then scan the ring for survivors (output stalls add).
// Time is data dependent, the longest walk being n = 64, step 255 and one survivor.
// One item at a time; the next is taken once the last result is in the output register.
// Reset clears the controller and output valid; the flag memory is rewritten per item.
module josephus_elimination_order #(
    parameter int MAX_PEOPLE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // total[6:0], start_pos[13:7], step[21:14], survivors[28:22]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // position[6:0], ordinal[13:7]
    output logic [2:0]  o_m_tuser,   // result_kind[2:0]
    output logic        o_m_tlast
);

    jos_pkg::t_cmd    cmd;
    jos_pkg::t_status status;

    jos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    jos_dp #(
        .MAX_PEOPLE (MAX_PEOPLE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int RING_MAX   = 64;
    localparam int RAND_ITEMS = 80;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_LEN   = 600;

    typedef struct packed {
        logic [jos_pkg::KIND_W-1:0] kind;
        logic [6:0]                 pos;
        logic [6:0]                 ordinal;
        logic                       is_last;
    } t_result;

    typedef struct packed {
        logic [6:0]                 total;
        logic [6:0]                 start_pos;
        logic [7:0]                 step;
        logic [6:0]                 survivors;
        logic                       typed;      // expectation written out below
        logic [jos_pkg::KIND_W-1:0] kind;
        logic [6:0]                 pos;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // total[6:0], start_pos[13:7], step[21:14], survivors[28:22]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // position[6:0], ordinal[13:7]
    logic [2:0]  o_m_tuser;         // result_kind[2:0]
    logic        o_m_tlast;

    josephus_elimination_order i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [RING_MAX-1:0] ring_alive;
    logic [5:0]          ring_cursor;
    logic [7:0]          hit_cnt;
    logic [6:0]          elim_cnt;

    t_result          pending_results[$];
    t_result          exp_r;
    int               mismatch_cnt = 0;
    int               results_seen = 0;
    int               idle_cycles  = 0;
    int               stall_phase  = 0;
    int               hold_left    = 0;
    bit               hold_done    = 1'b0;

    function automatic void push_result(input logic [jos_pkg::KIND_W-1:0] kind,
                                        input logic [6:0] pos,
                                        input int idx, input bit is_last);
        t_result r;
        r.kind    = kind;
        r.pos     = pos;
        r.ordinal = 7'(idx + 1);
        r.is_last = is_last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_elimination(input logic [6:0] total,
                                                input logic [6:0] start_pos,
                                                input logic [7:0] step,
                                                input logic [6:0] survivors);
        int ring_n;
        int produced;
        int j;
        produced = 0;
        ring_n   = (total > RING_MAX) ? RING_MAX : int'(total);
        if (ring_n == 0 || start_pos == 0 || step == 0 || survivors == 0) begin
            push_result(jos_pkg::KIND_NONPOS, 7'd0, 0, 1'b1);
        end else if (survivors > ring_n) begin
            push_result(jos_pkg::KIND_TOO_MANY, 7'd0, 0, 1'b1);
        end else if (start_pos > ring_n) begin
            push_result(jos_pkg::KIND_START, 7'd0, 0, 1'b1);
        end else begin
            for (j = 0; j < ring_n; j++)
                ring_alive[j] = 1'b1;
            // park one place before the start so the first advance lands on it
            ring_cursor = (start_pos >= 2) ? 6'(start_pos - 2) : 6'(ring_n - 1);
            elim_cnt    = '0;
            while (elim_cnt < ring_n - survivors) begin
                hit_cnt = '0;
                while (hit_cnt < step) begin
                    ring_cursor = 6'((int'(ring_cursor) + 1) % ring_n);
                    if (ring_alive[ring_cursor])
                        hit_cnt++;
                end
                ring_alive[ring_cursor] = 1'b0;
                elim_cnt++;
                push_result(jos_pkg::KIND_OUT, 7'(ring_cursor + 1), produced,
                            produced + 1 == ring_n);
                produced++;
            end
            for (j = 0; j < ring_n; j++) begin
                if (ring_alive[j]) begin
                    push_result(jos_pkg::KIND_SURV, 7'(j + 1), produced, produced + 1 == ring_n);
                    produced++;
                end
            end
        end
    endfunction

    task automatic offer_instance(input logic [6:0] total, input logic [6:0] start_pos,
                                  input logic [7:0] step, input logic [6:0] survivors);
        i_s_tdata  <= {3'b000, survivors, step, start_pos, total};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // receiver: one long hold-off once traffic is going, otherwise a rotating stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (!hold_done && results_seen >= 40) begin
            i_m_tready <= 1'b0;
            hold_left  <= HOLD_LEN;
            hold_done  <= 1'b1;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase >> 6) % 4)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= 1'($urandom_range(0, 1));
                2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d position %0d ordinal %0d last %0d",
                       o_m_tuser, o_m_tdata[6:0], o_m_tdata[13:7], o_m_tlast);
                mismatch_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_tuser !== exp_r.kind) begin
                    $error("result_kind: expected %0d, got %0d", exp_r.kind, o_m_tuser);
                    mismatch_cnt++;
                end
                if (o_m_tdata[6:0] !== exp_r.pos) begin
                    $error("position: expected %0d, got %0d", exp_r.pos, o_m_tdata[6:0]);
                    mismatch_cnt++;
                end
                if (o_m_tdata[13:7] !== exp_r.ordinal) begin
                    $error("ordinal: expected %0d, got %0d", exp_r.ordinal, o_m_tdata[13:7]);
                    mismatch_cnt++;
                end
                if (o_m_tlast !== exp_r.is_last) begin
                    $error("last: expected %0d, got %0d", exp_r.is_last, o_m_tlast);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row       directed_rows[21];
        logic [6:0] t, s, k;
        logic [7:0] m;
        int         ring_n;
        int         burst_left;
        int         gap;
        int         pick;

        directed_rows = '{
            '{7'd0,   7'd1,   8'd1,   7'd1,   1'b1, jos_pkg::KIND_NONPOS,   7'd0},
            '{7'd5,   7'd0,   8'd1,   7'd1,   1'b1, jos_pkg::KIND_NONPOS,   7'd0},
            '{7'd5,   7'd1,   8'd0,   7'd1,   1'b1, jos_pkg::KIND_NONPOS,   7'd0},
            '{7'd5,   7'd1,   8'd1,   7'd0,   1'b1, jos_pkg::KIND_NONPOS,   7'd0},
            '{7'd0,   7'd0,   8'd0,   7'd0,   1'b1, jos_pkg::KIND_NONPOS,   7'd0},
            '{7'd5,   7'd1,   8'd1,   7'd6,   1'b1, jos_pkg::KIND_TOO_MANY, 7'd0},
            '{7'd5,   7'd6,   8'd1,   7'd1,   1'b1, jos_pkg::KIND_START,    7'd0},
            // both survivors and start too big: survivors check wins
            '{7'd5,   7'd6,   8'd1,   7'd6,   1'b1, jos_pkg::KIND_TOO_MANY, 7'd0},
            '{7'd127, 7'd127, 8'd255, 7'd127, 1'b1, jos_pkg::KIND_TOO_MANY, 7'd0},
            // ring clamps to 64, so start 65 is out of range
            '{7'd127, 7'd65,  8'd1,   7'd1,   1'b1, jos_pkg::KIND_START,    7'd0},
            '{7'd1,   7'd1,   8'd1,   7'd1,   1'b1, jos_pkg::KIND_SURV,     7'd1},
            '{7'd7,   7'd1,   8'd3,   7'd1,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd41,  7'd1,   8'd3,   7'd2,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd5,   7'd5,   8'd2,   7'd5,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd6,   7'd6,   8'd6,   7'd3,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd2,   7'd2,   8'd255, 7'd1,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd10,  7'd1,   8'd1,   7'd9,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd127, 7'd1,   8'd1,   7'd1,   1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd100, 7'd3,   8'd200, 7'd64,  1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd64,  7'd1,   8'd128, 7'd63,  1'b0, jos_pkg::KIND_OUT,      7'd0},
            '{7'd64,  7'd64,  8'd255, 7'd1,   1'b0, jos_pkg::KIND_OUT,      7'd0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            offer_instance(directed_rows[r].total, directed_rows[r].start_pos,
                           directed_rows[r].step, directed_rows[r].survivors);
            if (directed_rows[r].typed)
                push_result(directed_rows[r].kind, directed_rows[r].pos, 0, 1'b1);
            else
                predict_elimination(directed_rows[r].total, directed_rows[r].start_pos,
                                    directed_rows[r].step, directed_rows[r].survivors);
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        burst_left = 0;
        for (int n_item = 0; n_item < RAND_ITEMS; n_item++) begin
            if (n_item == RAND_ITEMS / 2) begin
                // let the block drain completely before going on
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end else if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // malformed instance of one of the three error kinds
                t = 7'($urandom_range(1, 127));
                s = 7'($urandom_range(0, 127));
                m = 8'($urandom_range(0, 255));
                k = 7'($urandom_range(0, 127));
                ring_n = (t > RING_MAX) ? RING_MAX : int'(t);
                case ($urandom_range(0, 2))
                    0: begin
                        case ($urandom_range(0, 3))
                            0:       t = '0;
                            1:       s = '0;
                            2:       m = '0;
                            default: k = '0;
                        endcase
                    end
                    1: k = 7'($urandom_range(ring_n + 1, 127));
                    default: begin
                        m = 8'($urandom_range(1, 255));
                        k = 7'($urandom_range(1, ring_n));
                        s = 7'($urandom_range(ring_n + 1, 127));
                    end
                endcase
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    t = 7'($urandom_range(1, 16));
                else if (pick < 92)
                    t = 7'($urandom_range(17, 63));
                else
                    t = 7'($urandom_range(64, 127));
                ring_n = (t > RING_MAX) ? RING_MAX : int'(t);
                s = 7'($urandom_range(1, ring_n));
                k = 7'($urandom_range(1, ring_n));
                // long steps only on small rings to keep walk time bounded
                if (ring_n <= 16)
                    m = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(1, 12));
                else
                    m = 8'($urandom_range(1, 24));
            end
            offer_instance(t, s, m, k);
            predict_elimination(t, s, m, k);
        end

        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (50) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
